// ===== rtl/tsmi_pkg.sv =====
`default_nettype none
package tsmi_pkg;

   localparam int NUM_CHANNELS_DEF = 32;
   localparam int POS_MAX_DEF      = 127;
   localparam int RESULT_CAP       = 32;
   localparam int TIME_W           = 16;
   localparam int PULSE_W          = 12;
   localparam int SETUP_W          = 25;

   localparam logic [7:0]  MS_PER_STEP_RESET = 8'd2;
   localparam logic [15:0] HOLD_MS_RESET     = 16'd500;

   localparam logic [1:0] OP_SETUP    = 2'd0;
   localparam logic [1:0] OP_MOVE     = 2'd1;
   localparam logic [1:0] OP_TICK     = 2'd2;
   localparam logic [1:0] OP_RESERVED = 2'd3;

   localparam logic [1:0] ACT_NONE  = 2'd0;
   localparam logic [1:0] ACT_PULSE = 2'd1;
   localparam logic [1:0] ACT_OFF   = 2'd2;

   localparam logic REG_MS_PER_STEP = 1'b0;
   localparam logic REG_HOLD_MS     = 1'b1;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_RMW,
      ST_TICK_RD,
      ST_DIV1,
      ST_PULSE,
      ST_DIV2,
      ST_EMIT
   } state_type;

   typedef struct packed {
      logic busy;
      logic done;
   } div_stat_type;

   function automatic int pos_width(input int pos_max);
      return $clog2(pos_max + 1);
   endfunction

   function automatic int rec_width(input int pos_max);
      return 3 * pos_width(pos_max) + TIME_W + 32 + 1 + SETUP_W;
   endfunction

endpackage
`default_nettype wire

// ===== rtl/tsmi_if.sv =====
`default_nettype none
interface tsmi_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  op;
   logic [4:0]  channel_index;
   logic [7:0]  target_position;
   logic [15:0] move_time;
   logic [11:0] pulse_low;
   logic [11:0] pulse_high;
   logic        inverted;

   modport source (output valid, op, channel_index, target_position, move_time,
                   pulse_low, pulse_high, inverted, input ready);
   modport sink   (input valid, op, channel_index, target_position, move_time,
                   pulse_low, pulse_high, inverted, output ready);
endinterface

interface tsmi_rsp_if;
   logic        valid;
   logic        ready;
   logic [4:0]  out_channel;
   logic [1:0]  action;
   logic [11:0] pulse_width;
   logic        last;

   modport source (output valid, out_channel, action, pulse_width, last, input ready);
   modport sink   (input valid, out_channel, action, pulse_width, last, output ready);
endinterface
`default_nettype wire

// ===== rtl/tsmi_ram.sv =====
`default_nettype none
module tsmi_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 32,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic             clock,
   input  wire logic             we,
   input  wire logic [AW-1:0]    waddr,
   input  wire logic [WIDTH-1:0] wdata,
   input  wire logic [AW-1:0]    raddr,
   output logic      [WIDTH-1:0] rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata <= mem_ff[raddr];
   end

endmodule
`default_nettype wire

// ===== rtl/tsmi_div.sv =====
`default_nettype none
module tsmi_div #(
   parameter int NW = 24,
   parameter int DW = 16
) (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          start,
   input  wire logic [NW-1:0] dividend,
   input  wire logic [DW-1:0] divisor,
   output logic      [NW-1:0] quotient,
   output tsmi_pkg::div_stat_type stat
);

   // Two restoring steps per cycle.
   localparam int STEPS = (NW + 1) / 2;
   localparam int NP    = 2 * STEPS;
   localparam int CNTW  = $clog2(STEPS + 1);

   logic [NP-1:0]   quo_ff, quo_in;
   logic [DW:0]     rem_ff, rem_in;
   logic [DW-1:0]   dsr_ff, dsr_in;
   logic [CNTW-1:0] cnt_ff, cnt_in;
   logic            busy_ff, busy_in;
   logic            done_ff, done_in;

   always_comb begin
      logic [NP-1:0] q;
      logic [DW:0]   r;
      q       = quo_ff;
      r       = rem_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dsr_in  = dsr_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         quo_in  = NP'(dividend);
         rem_in  = '0;
         dsr_in  = divisor;
         cnt_in  = CNTW'(STEPS);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         for (int i = 0; i < 2; i++) begin
            r = {r[DW-1:0], q[NP-1]};
            q = {q[NP-2:0], 1'b0};
            if (r >= {1'b0, dsr_ff}) begin
               r    = r - {1'b0, dsr_ff};
               q[0] = 1'b1;
            end
         end
         quo_in = q;
         rem_in = r;
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CNTW'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dsr_ff <= dsr_in;
   end

   assign quotient  = quo_ff[NW-1:0];
   assign stat.busy = busy_ff;
   assign stat.done = done_ff;

endmodule
`default_nettype wire

// ===== rtl/tsmi_engine.sv =====
`default_nettype none
module tsmi_engine #(
   parameter int NUM_CHANNELS = tsmi_pkg::NUM_CHANNELS_DEF,
   parameter int POS_MAX      = tsmi_pkg::POS_MAX_DEF,
   parameter int NW           = 16 + tsmi_pkg::pos_width(POS_MAX),
   parameter int AW           = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1,
   parameter int RW           = tsmi_pkg::rec_width(POS_MAX)
) (
   input  wire logic              clock,
   input  wire logic              reset,
   tsmi_req_if.sink               req,
   tsmi_rsp_if.source             rsp,
   input  wire logic [7:0]        ms_per_step,
   input  wire logic [15:0]       hold_ms,
   output logic                   ram_we,
   output logic [AW-1:0]          ram_waddr,
   output logic [RW-1:0]          ram_wdata,
   output logic [AW-1:0]          ram_raddr,
   input  wire logic [RW-1:0]     ram_rdata,
   output logic                   div_start,
   output logic [NW-1:0]          div_dividend,
   output logic [15:0]            div_divisor,
   input  wire logic [NW-1:0]     div_quotient,
   input  wire tsmi_pkg::div_stat_type div_stat
);

   localparam int PW   = tsmi_pkg::pos_width(POS_MAX);
   localparam int CW   = $clog2(NUM_CHANNELS + 1);
   localparam int NRES = (NUM_CHANNELS < tsmi_pkg::RESULT_CAP) ?
                         NUM_CHANNELS : tsmi_pkg::RESULT_CAP;
   // The pulse scaling divides by POS_MAX through a reciprocal multiplication
   // that is exact for every product of a position and a 12-bit range.
   localparam int PX    = PW + 12;
   localparam int RSH   = PX + $clog2(POS_MAX);
   localparam int MW    = PX + 2;
   localparam logic [MW-1:0] RECIP = MW'((64'd1 << RSH) / POS_MAX + 1);

   typedef struct packed {
      logic [24:0]   setup;
      logic          off;
      logic [31:0]   cmd;
      logic [15:0]   allot;
      logic [PW-1:0] cur;
      logic [PW-1:0] fin;
      logic [PW-1:0] start;
   } rec_type;

   tsmi_pkg::state_type state_ff, state_in;
   logic [1:0]   op_ff, op_in;
   logic [AW-1:0] ch_ff, ch_in;
   logic [7:0]   tp_ff, tp_in;
   logic [15:0]  mt_ff, mt_in;
   logic [11:0]  lo_ff, lo_in;
   logic [11:0]  hi_ff, hi_in;
   logic         inv_ff, inv_in;
   logic [31:0]  now_ff, now_in;
   logic [CW-1:0] c_ff, c_in;
   rec_type      rec_ff, rec_in, rec_rd;
   logic [AW-1:0] rd_addr_ff;
   logic [NUM_CHANNELS-1:0] valid_ff, valid_in;
   logic [1:0]   act_ff, act_in;
   logic [11:0]  pulse_ff, pulse_in;
   logic         neg_ff, neg_in;
   logic [PX-1:0] prod_ff, prod_in;
   logic         rsp_valid_ff, rsp_valid_in;
   logic [4:0]   rsp_ch_ff, rsp_ch_in;
   logic [1:0]   rsp_act_ff, rsp_act_in;
   logic [11:0]  rsp_pulse_ff, rsp_pulse_in;
   logic         rsp_last_ff, rsp_last_in;

   // Entries never written read as the all-zero reset record.
   assign rec_rd = valid_ff[rd_addr_ff] ? rec_type'(ram_rdata) : '0;

   always_comb begin
      logic [7:0]     p8;
      logic [PW-1:0]  p, span, diff;
      logic [PW+7:0]  need_full;
      logic [15:0]    need;
      logic [31:0]    elapsed;
      logic [15+PW:0] iprod;
      logic [12:0]    d13;
      logic [11:0]    mag;
      logic [PX-1:0]  pprod;
      logic [PX+MW-1:0] rprod;
      logic [11:0]    q12;
      logic           emit, go;
      logic [CW-1:0]  c_next;

      state_in     = state_ff;
      op_in        = op_ff;
      ch_in        = ch_ff;
      tp_in        = tp_ff;
      mt_in        = mt_ff;
      lo_in        = lo_ff;
      hi_in        = hi_ff;
      inv_in       = inv_ff;
      now_in       = now_ff;
      c_in         = c_ff;
      rec_in       = rec_ff;
      valid_in     = valid_ff;
      act_in       = act_ff;
      pulse_in     = pulse_ff;
      neg_in       = neg_ff;
      prod_in      = prod_ff;
      rsp_valid_in = rsp_valid_ff & ~rsp.ready;
      rsp_ch_in    = rsp_ch_ff;
      rsp_act_in   = rsp_act_ff;
      rsp_pulse_in = rsp_pulse_ff;
      rsp_last_in  = rsp_last_ff;
      ram_we       = 1'b0;
      ram_waddr    = ch_ff;
      ram_wdata    = rec_ff;
      ram_raddr    = '0;
      div_start    = 1'b0;
      div_dividend = '0;
      div_divisor  = '0;
      req.ready    = (state_ff == tsmi_pkg::ST_IDLE);

      p8        = (tp_ff > 8'(POS_MAX)) ? 8'(POS_MAX) : tp_ff;
      p         = PW'(p8);
      if (rec_rd.setup[24]) begin
         p = PW'(POS_MAX) - p;
      end
      span      = (rec_rd.cur > p) ? rec_rd.cur - p : p - rec_rd.cur;
      need_full = span * ms_per_step;
      need      = 16'(need_full);

      elapsed = now_ff - rec_rd.cmd;
      diff    = (rec_rd.fin >= rec_rd.start) ? rec_rd.fin - rec_rd.start
                                             : rec_rd.start - rec_rd.fin;
      iprod   = elapsed[15:0] * diff;

      d13   = {1'b0, rec_ff.setup[23:12]} - {1'b0, rec_ff.setup[11:0]};
      mag   = d13[12] ? 12'(-d13) : d13[11:0];
      pprod = rec_ff.cur * mag;
      rprod = prod_ff * RECIP;
      q12   = rprod[RSH +: 12];

      emit   = (c_ff < CW'(NRES));
      go     = !emit || !rsp_valid_ff || rsp.ready;
      c_next = c_ff + 1'b1;

      case (state_ff)
         tsmi_pkg::ST_IDLE: begin
            ram_raddr = (req.op == tsmi_pkg::OP_TICK) ? '0 : AW'(req.channel_index);
            if (req.valid) begin
               op_in  = req.op;
               ch_in  = AW'(req.channel_index);
               tp_in  = req.target_position;
               mt_in  = req.move_time;
               lo_in  = req.pulse_low;
               hi_in  = req.pulse_high;
               inv_in = req.inverted;
               case (req.op)
                  tsmi_pkg::OP_SETUP, tsmi_pkg::OP_MOVE: begin
                     if (int'(req.channel_index) < NUM_CHANNELS) begin
                        state_in = tsmi_pkg::ST_RMW;
                     end
                  end
                  tsmi_pkg::OP_TICK: begin
                     now_in   = now_ff + 1'b1;
                     c_in     = '0;
                     state_in = tsmi_pkg::ST_TICK_RD;
                  end
                  default: ;
               endcase
            end
         end
         tsmi_pkg::ST_RMW: begin
            rec_in = rec_rd;
            if (op_ff == tsmi_pkg::OP_SETUP) begin
               rec_in.setup = {inv_ff, hi_ff, lo_ff};
            end else begin
               rec_in.start = rec_rd.cur;
               rec_in.fin   = p;
               rec_in.allot = (need > mt_ff) ? need : mt_ff;
               rec_in.cmd   = now_ff;
               rec_in.off   = 1'b0;
            end
            ram_we          = 1'b1;
            ram_waddr       = ch_ff;
            ram_wdata       = rec_in;
            valid_in[ch_ff] = 1'b1;
            state_in        = tsmi_pkg::ST_IDLE;
         end
         tsmi_pkg::ST_TICK_RD: begin
            rec_in   = rec_rd;
            act_in   = tsmi_pkg::ACT_NONE;
            pulse_in = '0;
            if (rec_rd.cur != rec_rd.fin) begin
               act_in = tsmi_pkg::ACT_PULSE;
               if (elapsed >= {16'd0, rec_rd.allot}) begin
                  rec_in.cur = rec_rd.fin;
                  state_in   = tsmi_pkg::ST_PULSE;
               end else begin
                  div_start    = 1'b1;
                  div_dividend = NW'(iprod);
                  div_divisor  = rec_rd.allot;
                  state_in     = tsmi_pkg::ST_DIV1;
               end
            end else begin
               if ((elapsed > ({16'd0, rec_rd.allot} + {16'd0, hold_ms})) &&
                   !rec_rd.off) begin
                  rec_in.off = 1'b1;
                  act_in     = tsmi_pkg::ACT_OFF;
               end
               state_in = tsmi_pkg::ST_EMIT;
            end
         end
         tsmi_pkg::ST_DIV1: begin
            if (div_stat.done) begin
               if (rec_ff.fin >= rec_ff.start) begin
                  rec_in.cur = rec_ff.start + div_quotient[PW-1:0];
               end else begin
                  rec_in.cur = rec_ff.start - div_quotient[PW-1:0];
               end
               state_in = tsmi_pkg::ST_PULSE;
            end
         end
         tsmi_pkg::ST_PULSE: begin
            prod_in  = pprod;
            neg_in   = d13[12];
            state_in = tsmi_pkg::ST_DIV2;
         end
         tsmi_pkg::ST_DIV2: begin
            pulse_in = neg_ff ? rec_ff.setup[11:0] - q12 : rec_ff.setup[11:0] + q12;
            state_in = tsmi_pkg::ST_EMIT;
         end
         tsmi_pkg::ST_EMIT: begin
            if (go) begin
               ram_we                 = 1'b1;
               ram_waddr              = c_ff[AW-1:0];
               ram_wdata              = rec_ff;
               valid_in[c_ff[AW-1:0]] = 1'b1;
               if (emit) begin
                  rsp_valid_in = 1'b1;
                  rsp_ch_in    = 5'(c_ff);
                  rsp_act_in   = act_ff;
                  rsp_pulse_in = pulse_ff;
                  rsp_last_in  = (c_ff == CW'(NRES - 1));
               end
               if (c_ff == CW'(NUM_CHANNELS - 1)) begin
                  state_in = tsmi_pkg::ST_IDLE;
               end else begin
                  c_in      = c_next;
                  ram_raddr = c_next[AW-1:0];
                  state_in  = tsmi_pkg::ST_TICK_RD;
               end
            end
         end
         default: state_in = tsmi_pkg::ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= tsmi_pkg::ST_IDLE;
         now_ff       <= '0;
         c_ff         <= '0;
         valid_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         now_ff       <= now_in;
         c_ff         <= c_in;
         valid_ff     <= valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      op_ff        <= op_in;
      ch_ff        <= ch_in;
      tp_ff        <= tp_in;
      mt_ff        <= mt_in;
      lo_ff        <= lo_in;
      hi_ff        <= hi_in;
      inv_ff       <= inv_in;
      rec_ff       <= rec_in;
      rd_addr_ff   <= ram_raddr;
      act_ff       <= act_in;
      pulse_ff     <= pulse_in;
      neg_ff       <= neg_in;
      prod_ff      <= prod_in;
      rsp_ch_ff    <= rsp_ch_in;
      rsp_act_ff   <= rsp_act_in;
      rsp_pulse_ff <= rsp_pulse_in;
      rsp_last_ff  <= rsp_last_in;
   end

   assign rsp.valid       = rsp_valid_ff;
   assign rsp.out_channel = rsp_ch_ff;
   assign rsp.action      = rsp_act_ff;
   assign rsp.pulse_width = rsp_pulse_ff;
   assign rsp.last        = rsp_last_ff;

endmodule
`default_nettype wire

// ===== rtl/timed_servo_move_interpolator.sv =====
`default_nettype none
// Multi-channel servo move interpolator.
// Commands arrive as transactions on the req channel: a setup transaction stores a
// channel's pulse range and inversion flag, a move transaction starts a timed move,
// and a tick transaction advances the millisecond clock and walks every channel.
// Each tick returns one rsp transaction per channel (up to 32) in channel order,
// with last set on the final one; setup and move return nothing.
// Per-channel records live in one synchronous RAM with a registered read; the
// engine reads a channel's record, updates it and writes it back.
// Setup and move write the updated record back in the RMW state. On a tick each
// channel's record is read; a channel at rest goes straight to EMIT, a moving
// channel that has used up its time passes through PULSE and DIV2, and one that
// is still interpolating first waits in DIV1 for the two-bit-per-cycle divider;
// the pulse scaling in DIV2 is a reciprocal multiplication.
// One item is worked on at a time; req.ready is high only while the engine idles.
// Results sit in an output register, so a stalled receiver holds the engine only
// when the next result is due; the next command is accepted meanwhile.
// Reset clears the millisecond clock and the per-record valid bits, so every channel
// reads as zero until written; ms_per_step resets to 2 and hold_ms to 500.
// Registers on the csr port: ms_per_step at address 0, hold_ms at address 4.
module timed_servo_move_interpolator #(
   parameter int NUM_CHANNELS = tsmi_pkg::NUM_CHANNELS_DEF,
   parameter int POS_MAX      = tsmi_pkg::POS_MAX_DEF
) (
   input  wire logic        clock,
   input  wire logic        reset,
   tsmi_req_if.sink         req,
   tsmi_rsp_if.source       rsp,
   input  wire logic        csr_psel,
   input  wire logic        csr_penable,
   input  wire logic        csr_pwrite,
   input  wire logic [2:0]  csr_paddr,
   input  wire logic [31:0] csr_pwdata,
   output logic      [31:0] csr_prdata,
   output logic             csr_pready
);

   localparam int PW = tsmi_pkg::pos_width(POS_MAX);
   localparam int NW = 16 + PW;
   localparam int AW = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
   localparam int RW = tsmi_pkg::rec_width(POS_MAX);

   logic [7:0]  ms_ff, ms_in;
   logic [15:0] hold_ff, hold_in;
   logic        csr_wr;

   // Register write happens in the access phase; pready never stalls.
   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite;

   always_comb begin
      ms_in   = ms_ff;
      hold_in = hold_ff;
      if (csr_wr) begin
         case (csr_paddr[2])
            tsmi_pkg::REG_MS_PER_STEP: ms_in   = csr_pwdata[7:0];
            tsmi_pkg::REG_HOLD_MS:     hold_in = csr_pwdata[15:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ms_ff   <= tsmi_pkg::MS_PER_STEP_RESET;
         hold_ff <= tsmi_pkg::HOLD_MS_RESET;
      end else begin
         ms_ff   <= ms_in;
         hold_ff <= hold_in;
      end
   end

   assign csr_prdata = (csr_paddr[2] == tsmi_pkg::REG_HOLD_MS) ? {16'd0, hold_ff}
                                                               : {24'd0, ms_ff};

   logic          ram_we;
   logic [AW-1:0] ram_waddr, ram_raddr;
   logic [RW-1:0] ram_wdata, ram_rdata;
   logic          div_start;
   logic [NW-1:0] div_dividend, div_quotient;
   logic [15:0]   div_divisor;
   tsmi_pkg::div_stat_type div_stat;

   tsmi_ram #(.WIDTH(RW), .DEPTH(NUM_CHANNELS)) u_ram (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .raddr (ram_raddr),
      .rdata (ram_rdata)
   );

   tsmi_div #(.NW(NW), .DW(16)) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .quotient (div_quotient),
      .stat     (div_stat)
   );

   tsmi_engine #(
      .NUM_CHANNELS (NUM_CHANNELS),
      .POS_MAX      (POS_MAX),
      .NW           (NW),
      .AW           (AW),
      .RW           (RW)
   ) u_engine (
      .clock        (clock),
      .reset        (reset),
      .req          (req),
      .rsp          (rsp),
      .ms_per_step  (ms_ff),
      .hold_ms      (hold_ff),
      .ram_we       (ram_we),
      .ram_waddr    (ram_waddr),
      .ram_wdata    (ram_wdata),
      .ram_raddr    (ram_raddr),
      .ram_rdata    (ram_rdata),
      .div_start    (div_start),
      .div_dividend (div_dividend),
      .div_divisor  (div_divisor),
      .div_quotient (div_quotient),
      .div_stat     (div_stat)
   );

   // The shared divider must never be restarted while a division is running.
   assert property (@(posedge clock) disable iff (reset) div_start |-> !div_stat.busy)
      else $error("divider started while busy");

   // A new command is never taken while a division is in flight.
   assert property (@(posedge clock) disable iff (reset) div_stat.busy |-> !req.ready)
      else $error("command accepted during a division");

   // A switch-off or no-change result always carries a zero pulse.
   assert property (@(posedge clock) disable iff (reset)
                    rsp.valid && (rsp.action != tsmi_pkg::ACT_PULSE)
                    |-> rsp.pulse_width == 12'd0)
      else $error("nonzero pulse on a result without a drive action");

   // Starting a division is followed in the next cycle by a busy divider.
   assert property (@(posedge clock) disable iff (reset) div_start |=> div_stat.busy)
      else $error("divider did not start");

endmodule
`default_nettype wire
